@@ rtl/contact_penalty_energy_derivatives_defines.svh @@
// Assertion macros for the contact penalty block
`ifndef CONTACT_PENALTY_ENERGY_DERIVATIVES_DEFINES_SVH
`define CONTACT_PENALTY_ENERGY_DERIVATIVES_DEFINES_SVH

// condition holds at every edge out of reset
`define CPE_CHECK(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// antecedent implies consequent in the same cycle
`define CPE_CHECK_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ rtl/cpe_pkg.sv @@
// Shared types, constants and helper functions of the contact penalty pipeline
package cpe_pkg;

	localparam int NUM_STAGES = 11;

	typedef enum logic [1:0] {
		CFG_STIFFNESS = 2'd0,
		CFG_FRICTION  = 2'd1,
		CFG_DAMPING   = 2'd2,
		CFG_INV_STEP  = 2'd3
	} cfg_index_t;

	// unique entries of the symmetric 3x3 matrix: xx xy xz yy yz zz
	localparam int PAIR_ROW [6] = '{0, 0, 0, 1, 1, 2};
	localparam int PAIR_COL [6] = '{0, 1, 2, 1, 2, 2};
	localparam int PAIR_IDX [3][3] = '{'{0, 1, 2}, '{1, 3, 4}, '{2, 4, 5}};

	localparam logic signed [20:0] ONE_Q16 = 21'sd65536;
	localparam logic [62:0] CAP62 = 63'h4000_0000_0000_0000;
	localparam logic signed [47:0] OUT_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] OUT_MIN = -OUT_MAX - 48'sd1;
	localparam logic signed [57:0] WIDE_MAX = 58'sh7FFF_FFFF_FFFF;
	localparam logic signed [57:0] WIDE_MIN = -WIDE_MAX - 58'sd1;
	localparam logic [46:0] ENERGY_MAX = '1;

	typedef struct packed {
		logic [19:0] stiffness;
		logic [19:0] friction;
		logic [19:0] damping;
		logic [35:0] fric_hess;
		logic [35:0] damp_hess;
	} coef_t;

	typedef struct packed {
		logic [19:0]       idx;
		logic [2:0][31:0]  vel;
		logic [5:0][19:0]  nn;
		logic [2:0][33:0]  nd;
		logic [46:0]       sqd;
	} geom_t;

	typedef struct packed {
		logic [19:0]       idx;
		logic [5:0][47:0]  hess;
		logic [62:0]       pen;
		logic [2:0][53:0]  knd;
		logic [2:0][55:0]  muvt;
		logic [2:0][55:0]  cvn;
		logic [2:0][34:0]  mvt;
		logic [2:0][34:0]  mvn;
	} proj_t;

	typedef struct packed {
		logic [19:0]       idx;
		logic [46:0]       energy;
		logic [2:0][47:0]  grad;
		logic [5:0][47:0]  hess;
	} res_t;

	// join a product split at bit 30 and saturate at 2^62
	function automatic logic [62:0] sat_join(input logic [49:0] hi_p, input logic [49:0] lo_p);
		logic [80:0] full;
		full = {1'b0, hi_p, 30'd0} + {31'd0, lo_p};
		return (full > {18'd0, CAP62}) ? CAP62 : full[62:0];
	endfunction

	function automatic logic [47:0] clamp48(input logic signed [57:0] v);
		logic [47:0] r;
		if (v > WIDE_MAX) begin
			r = OUT_MAX;
		end else if (v < WIDE_MIN) begin
			r = OUT_MIN;
		end else begin
			r = v[47:0];
		end
		return r;
	endfunction

	function automatic logic [46:0] clamp_energy(input logic [63:0] e);
		return (e > {17'd0, ENERGY_MAX}) ? ENERGY_MAX : e[46:0];
	endfunction

endpackage

@@ rtl/cpe_geom.sv @@
// Normal outer products, normal-distance products and distance square (two stages)
module cpe_geom
	import cpe_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [19:0]      idx,
	input  logic [2:0][17:0] normal,
	input  logic [31:0]      gap,
	input  logic [2:0][31:0] vel,
	output logic             out_valid,
	input  logic             out_ready,
	output geom_t            out
);

	logic valid_s1, valid_s2;
	logic en_s1, en_s2;

	logic signed [35:0] pnn_s1 [6];
	logic signed [49:0] pnd_s1 [3];
	logic signed [63:0] pdd_s1;
	logic [19:0]        idx_s1;
	logic [2:0][31:0]   vel_s1;

	geom_t geom_s2;

	logic signed [36:0] rnn [6];
	logic signed [50:0] rnd [3];
	logic [63:0]        rdd;

	assign en_s2     = !valid_s2 || out_ready;
	assign en_s1     = !valid_s1 || en_s2;
	assign in_ready  = en_s1;
	assign out_valid = valid_s2;
	assign out       = geom_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int p = 0; p < 6; p++) begin
				pnn_s1[p] <= $signed(normal[PAIR_ROW[p]]) * $signed(normal[PAIR_COL[p]]);
			end
			for (int a = 0; a < 3; a++) begin
				pnd_s1[a] <= $signed(normal[a]) * $signed(gap);
			end
			pdd_s1 <= $signed(gap) * $signed(gap);
			idx_s1 <= idx;
			vel_s1 <= vel;
		end
	end

	always_comb begin
		for (int p = 0; p < 6; p++) begin
			rnn[p] = pnn_s1[p] + 37'sd32768;
		end
		for (int a = 0; a < 3; a++) begin
			rnd[a] = pnd_s1[a] + 51'sd32768;
		end
		rdd = pdd_s1 + 64'd32768;
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int p = 0; p < 6; p++) begin
				geom_s2.nn[p] <= rnn[p][35:16];
			end
			for (int a = 0; a < 3; a++) begin
				geom_s2.nd[a] <= rnd[a][49:16];
			end
			geom_s2.sqd <= rdd[62:16];
			geom_s2.idx <= idx_s1;
			geom_s2.vel <= vel_s1;
		end
	end

endmodule

@@ rtl/cpe_proj.sv @@
// Velocity projection, Hessian entries, penalty energy and gradient products (three stages)
module cpe_proj
	import cpe_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  geom_t in,
	input  coef_t coef,
	output logic  out_valid,
	input  logic  out_ready,
	output proj_t out
);

	logic valid_s3, valid_s4, valid_s5;
	logic en_s3, en_s4, en_s5;

	logic signed [51:0] pv_s3 [3][3];
	logic signed [57:0] hk_s3 [6];
	logic signed [57:0] hf_s3 [6];
	logic signed [57:0] hd_s3 [6];
	logic signed [53:0] knd_s3 [3];
	logic [49:0]        pk_lo_s3;
	logic [49:0]        pk_hi_s3;
	logic signed [31:0] vel_s3 [3];
	logic [19:0]        idx_s3;

	logic signed [35:0] vn_s4 [3];
	logic signed [35:0] vt_s4 [3];
	logic [5:0][47:0]   hess_s4;
	logic [62:0]        pen_s4;
	logic [2:0][53:0]   knd_s4;
	logic [19:0]        idx_s4;

	proj_t proj_s5;

	logic signed [20:0] idn [6];
	logic signed [52:0] acc [3];
	logic signed [35:0] vt_c [3];
	logic signed [57:0] hsum [6];

	assign en_s5     = !valid_s5 || out_ready;
	assign en_s4     = !valid_s4 || en_s5;
	assign en_s3     = !valid_s3 || en_s4;
	assign in_ready  = en_s3;
	assign out_valid = valid_s5;
	assign out       = proj_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s3) valid_s3 <= in_valid;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
		end
	end

	always_comb begin
		for (int p = 0; p < 6; p++) begin
			idn[p] = ((PAIR_ROW[p] == PAIR_COL[p]) ? ONE_Q16 : 21'sd0) - $signed(in.nn[p]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int a = 0; a < 3; a++) begin
				for (int b = 0; b < 3; b++) begin
					pv_s3[a][b] <= $signed(in.nn[PAIR_IDX[a][b]]) * $signed(in.vel[b]);
				end
				knd_s3[a] <= $signed({1'b0, coef.stiffness}) * $signed(in.nd[a]);
				vel_s3[a] <= $signed(in.vel[a]);
			end
			for (int p = 0; p < 6; p++) begin
				hk_s3[p] <= $signed({1'b0, coef.stiffness}) * $signed(in.nn[p]);
				hf_s3[p] <= $signed({1'b0, coef.fric_hess}) * idn[p];
				hd_s3[p] <= $signed({1'b0, coef.damp_hess}) * $signed(in.nn[p]);
			end
			pk_lo_s3 <= coef.stiffness * in.sqd[29:0];
			pk_hi_s3 <= coef.stiffness * in.sqd[46:30];
			idx_s3   <= in.idx;
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			acc[a]  = pv_s3[a][0] + pv_s3[a][1] + pv_s3[a][2] + 53'sd32768;
			vt_c[a] = vel_s3[a] - $signed(acc[a][51:16]);
		end
		for (int p = 0; p < 6; p++) begin
			hsum[p] = hk_s3[p] + hf_s3[p] + hd_s3[p];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int a = 0; a < 3; a++) begin
				vn_s4[a]  <= acc[a][51:16];
				vt_s4[a]  <= vt_c[a];
				knd_s4[a] <= knd_s3[a];
			end
			for (int p = 0; p < 6; p++) begin
				hess_s4[p] <= clamp48(hsum[p]);
			end
			pen_s4 <= sat_join(pk_hi_s3, pk_lo_s3);
			idx_s4 <= idx_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			for (int a = 0; a < 3; a++) begin
				proj_s5.muvt[a] <= $signed({1'b0, coef.friction}) * vt_s4[a];
				proj_s5.cvn[a]  <= $signed({1'b0, coef.damping}) * vn_s4[a];
				proj_s5.mvt[a]  <= vt_s4[a][35] ? 35'(-vt_s4[a]) : vt_s4[a][34:0];
				proj_s5.mvn[a]  <= vn_s4[a][35] ? 35'(-vn_s4[a]) : vn_s4[a][34:0];
			end
			proj_s5.knd  <= knd_s4;
			proj_s5.hess <= hess_s4;
			proj_s5.pen  <= pen_s4;
			proj_s5.idx  <= idx_s4;
		end
	end

endmodule

@@ rtl/cpe_energy.sv @@
// Gradient sum, velocity squares and energy total with output register (six stages)
module cpe_energy
	import cpe_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  proj_t in,
	input  coef_t coef,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  out
);

	typedef struct packed {
		logic [19:0]      idx;
		logic [2:0][47:0] grad;
		logic [5:0][47:0] hess;
		logic [62:0]      pen;
	} carry_t;

	logic valid_s6, valid_s7, valid_s8, valid_s9, valid_s10, valid_s11;
	logic en_s6, en_s7, en_s8, en_s9, en_s10, en_s11;

	carry_t carry_s6, carry_s7, carry_s8, carry_s9, carry_s10;

	logic [37:0] hh_s6 [6];
	logic [34:0] hl_s6 [6];
	logic [31:0] ll_s6 [6];
	logic [55:0] sq_s7 [6];
	logic [55:0] st_s8, sn_s8;
	logic [49:0] fl_s9, fh_s9, dl_s9, dh_s9;
	logic [62:0] fric_s10, damp_s10;
	res_t        res_s11;

	logic [34:0]        mag [6];
	logic signed [57:0] gsum [3];
	logic [32:0]        llr [6];
	logic [63:0]        half_f, half_d, e_sum;

	assign en_s11    = !valid_s11 || out_ready;
	assign en_s10    = !valid_s10 || en_s11;
	assign en_s9     = !valid_s9 || en_s10;
	assign en_s8     = !valid_s8 || en_s9;
	assign en_s7     = !valid_s7 || en_s8;
	assign en_s6     = !valid_s6 || en_s7;
	assign in_ready  = en_s6;
	assign out_valid = valid_s11;
	assign out       = res_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
			valid_s11 <= 1'b0;
		end else begin
			if (en_s6) valid_s6 <= in_valid;
			if (en_s7) valid_s7 <= valid_s6;
			if (en_s8) valid_s8 <= valid_s7;
			if (en_s9) valid_s9 <= valid_s8;
			if (en_s10) valid_s10 <= valid_s9;
			if (en_s11) valid_s11 <= valid_s10;
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			mag[a]     = in.mvt[a];
			mag[a + 3] = in.mvn[a];
			gsum[a]    = $signed(in.knd[a]) + $signed(in.muvt[a]) + $signed(in.cvn[a]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			for (int q = 0; q < 6; q++) begin
				hh_s6[q] <= mag[q][34:16] * mag[q][34:16];
				hl_s6[q] <= mag[q][34:16] * mag[q][15:0];
				ll_s6[q] <= mag[q][15:0] * mag[q][15:0];
			end
			for (int a = 0; a < 3; a++) begin
				carry_s6.grad[a] <= clamp48(gsum[a]);
			end
			carry_s6.hess <= in.hess;
			carry_s6.pen  <= in.pen;
			carry_s6.idx  <= in.idx;
		end
	end

	always_comb begin
		for (int q = 0; q < 6; q++) begin
			llr[q] = {1'b0, ll_s6[q]} + 33'd32768;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7) begin
			for (int q = 0; q < 6; q++) begin
				sq_s7[q] <= {2'd0, hh_s6[q], 16'd0} + {20'd0, hl_s6[q], 1'b0}
					+ {39'd0, llr[q][32:16]};
			end
			carry_s7 <= carry_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s8) begin
			st_s8    <= sq_s7[0] + sq_s7[1] + sq_s7[2];
			sn_s8    <= sq_s7[3] + sq_s7[4] + sq_s7[5];
			carry_s8 <= carry_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s9) begin
			fl_s9    <= coef.friction * st_s8[29:0];
			fh_s9    <= coef.friction * st_s8[55:30];
			dl_s9    <= coef.damping * sn_s8[29:0];
			dh_s9    <= coef.damping * sn_s8[55:30];
			carry_s9 <= carry_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s10) begin
			fric_s10  <= sat_join(fh_s9, fl_s9);
			damp_s10  <= sat_join(dh_s9, dl_s9);
			carry_s10 <= carry_s9;
		end
	end

	always_comb begin
		half_f = ({1'b0, fric_s10} + 64'd1) >> 1;
		half_d = ({1'b0, damp_s10} + 64'd1) >> 1;
		e_sum  = {1'b0, carry_s10.pen} + half_f + half_d;
	end

	always_ff @(posedge clk) begin
		if (en_s11) begin
			res_s11.energy <= clamp_energy(e_sum);
			res_s11.grad   <= carry_s10.grad;
			res_s11.hess   <= carry_s10.hess;
			res_s11.idx    <= carry_s10.idx;
		end
	end

endmodule

@@ rtl/contact_penalty_energy_derivatives.sv @@
// Top level of the contact penalty energy, gradient and Hessian pipeline
//
// Usage:
//   One contact event enters on the event channel (event_valid/event_ready)
//   and exactly one result leaves on the result channel
//   (result_valid/result_ready), in order. A transfer happens on a clock
//   edge with valid and ready both high.
//   result_valid rises once an event has passed the eleven register
//   stages of the multiply, round and saturate chain. Throughput is one
//   event per cycle while the receiver takes results. When the receiver
//   holds result_ready low, the output register keeps the result and the
//   stages behind it fill up; event_ready drops only once every stage
//   holds an item. No item is lost or repeated on a stall. Coefficients
//   are written through write_enable/write_index/write_data by the user
//   only while no events are in flight; the block does not enforce this.
//   They take effect for the next event. Reset clears all valid bits and
//   loads the default coefficients (k 100000, mu 100, c 1000, inverse
//   step 100).
`include "contact_penalty_energy_derivatives_defines.svh"

module contact_penalty_energy_derivatives
	import cpe_pkg::*;
#(
	parameter int INDEX_WIDTH = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               event_valid,
	output logic               event_ready,
	input  logic [19:0]        dof_index,
	input  logic signed [17:0] normal_x,
	input  logic signed [17:0] normal_y,
	input  logic signed [17:0] normal_z,
	input  logic signed [31:0] penetration,
	input  logic signed [31:0] velocity_x,
	input  logic signed [31:0] velocity_y,
	input  logic signed [31:0] velocity_z,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [19:0]        out_index,
	output logic [46:0]        energy,
	output logic signed [47:0] grad_x,
	output logic signed [47:0] grad_y,
	output logic signed [47:0] grad_z,
	output logic signed [47:0] hess_xx,
	output logic signed [47:0] hess_xy,
	output logic signed [47:0] hess_xz,
	output logic signed [47:0] hess_yy,
	output logic signed [47:0] hess_yz,
	output logic signed [47:0] hess_zz,
	input  logic               write_enable,
	input  logic [1:0]         write_index,
	input  logic [19:0]        write_data
);

	localparam int KEEP_BITS = (INDEX_WIDTH < 20) ? INDEX_WIDTH : 20;
	localparam logic [19:0] INDEX_MASK = 20'((64'd1 << KEEP_BITS) - 64'd1);
	localparam int CNT_W = $clog2(NUM_STAGES + 1);

	logic [19:0] stiffness_q, friction_q, damping_q;
	logic [15:0] inv_step_q;
	logic [35:0] fric_hess_q, damp_hess_q;
	coef_t       coef;

	logic  geom_valid, geom_ready, proj_valid, proj_ready;
	geom_t geom;
	proj_t proj;
	res_t  res;

	logic [CNT_W-1:0] inflight_q;
	logic             in_xfer, out_xfer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiffness_q <= 20'd100000;
			friction_q  <= 20'd100;
			damping_q   <= 20'd1000;
			inv_step_q  <= 16'd100;
		end else if (write_enable) begin
			unique case (cfg_index_t'(write_index))
				CFG_STIFFNESS: stiffness_q <= write_data;
				CFG_FRICTION:  friction_q  <= write_data;
				CFG_DAMPING:   damping_q   <= write_data;
				CFG_INV_STEP:  inv_step_q  <= write_data[15:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fric_hess_q <= 36'd10000;
			damp_hess_q <= 36'd100000;
		end else begin
			fric_hess_q <= inv_step_q * friction_q;
			damp_hess_q <= inv_step_q * damping_q;
		end
	end

	always_comb begin
		coef.stiffness = stiffness_q;
		coef.friction  = friction_q;
		coef.damping   = damping_q;
		coef.fric_hess = fric_hess_q;
		coef.damp_hess = damp_hess_q;
	end

	cpe_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (event_valid),
		.in_ready  (event_ready),
		.idx       (dof_index & INDEX_MASK),
		.normal    ({normal_z, normal_y, normal_x}),
		.gap       (penetration),
		.vel       ({velocity_z, velocity_y, velocity_x}),
		.out_valid (geom_valid),
		.out_ready (geom_ready),
		.out       (geom)
	);

	cpe_proj u_proj (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (geom_valid),
		.in_ready  (geom_ready),
		.in        (geom),
		.coef      (coef),
		.out_valid (proj_valid),
		.out_ready (proj_ready),
		.out       (proj)
	);

	cpe_energy u_energy (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (proj_valid),
		.in_ready  (proj_ready),
		.in        (proj),
		.coef      (coef),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.out       (res)
	);

	assign out_index = res.idx;
	assign energy    = res.energy;
	assign grad_x    = res.grad[0];
	assign grad_y    = res.grad[1];
	assign grad_z    = res.grad[2];
	assign hess_xx   = res.hess[0];
	assign hess_xy   = res.hess[1];
	assign hess_xz   = res.hess[2];
	assign hess_yy   = res.hess[3];
	assign hess_yz   = res.hess[4];
	assign hess_zz   = res.hess[5];

	assign in_xfer  = event_valid && event_ready;
	assign out_xfer = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			inflight_q <= inflight_q + CNT_W'(1);
		end else if (!in_xfer && out_xfer) begin
			inflight_q <= inflight_q - CNT_W'(1);
		end
	end

	`CPE_CHECK_IMPL(a_ready_drop, !event_ready, result_valid && !result_ready, "early stall")
	`CPE_CHECK(a_inflight_bound, inflight_q <= CNT_W'(NUM_STAGES), "too many in flight")
	`CPE_CHECK_IMPL(a_result_has_event, result_valid, inflight_q != '0, "orphan result")
	`CPE_CHECK_IMPL(a_full_pipe_valid, inflight_q == CNT_W'(NUM_STAGES), result_valid, "no result")

endmodule
